FILE: hw/rtl/isc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the interval sequence countdown timer.
// No dependencies; every other file of the block imports this package.
package isc_pkg;

  // Fixed field widths of the command and result beats.
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IDX_FIELD_W = 4;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned SEQ_LEN_W  = 5;

  // Configuration port geometry.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Register indexes on the configuration port (paddr[2]).
  localparam logic REG_SEQ_LEN = 1'b0;

  // Reset value of the sequence length register.
  localparam logic [SEQ_LEN_W-1:0] SEQ_LEN_RESET = 5'd1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  // Result status codes.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // One interval as held in the table.
  typedef struct packed {
    logic [COUNT_W-1:0] wrap;
    logic [COUNT_W-1:0] step;
  } table_entry_t;

endpackage

FILE: hw/rtl/isc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command beats and result beats.
// Depends on isc_pkg for the field widths.
interface isc_cmd_if import isc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic [IDX_FIELD_W-1:0] entry_index;
  logic [COUNT_W-1:0]     wrap_count;
  logic [COUNT_W-1:0]     step_count;

  modport source (output valid, command, entry_index, wrap_count, step_count,
                  input ready);
  modport sink (input valid, command, entry_index, wrap_count, step_count,
                output ready);
endinterface

interface isc_res_if import isc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   status;
  logic                   interval_done;
  logic [IDX_FIELD_W-1:0] done_index;
  logic                   sequence_last;
  logic                   busy_res;

  modport source (output valid, status, interval_done, done_index, sequence_last,
                  busy_res, input ready);
  modport sink (input valid, status, interval_done, done_index, sequence_last,
                busy_res, output ready);
endinterface

FILE: hw/rtl/isc_apb_regs.sv
`timescale 1ns / 1ps
// APB-style configuration register file holding the sequence length.
// Depends on isc_pkg.
module isc_apb_regs import isc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  output logic [SEQ_LEN_W-1:0] seq_len
);

  logic wr_fire;

  // The port never inserts wait states.
  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;

  // Sequence length register, written in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len <= SEQ_LEN_RESET;
    end else if (wr_fire && (paddr[2] == REG_SEQ_LEN)) begin
      seq_len <= pwdata[SEQ_LEN_W-1:0];
    end
  end

  // Read back; addresses past the register list read as zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SEQ_LEN) begin
      prdata = PDATA_W'(seq_len);
    end
  end

endmodule

FILE: hw/rtl/isc_table.sv
`timescale 1ns / 1ps
// Interval table: one write port and one registered read port.
// Depends on isc_pkg for the entry type.
module isc_table import isc_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic         clk,
  input  logic         wr_en,
  input  logic [AW-1:0] wr_addr,
  input  table_entry_t wr_entry,
  input  logic [AW-1:0] rd_addr,
  output table_entry_t rd_entry
);

  table_entry_t mem [DEPTH];

  // Contents are undefined until loaded, so there is no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/isc_ctrl.sv
`timescale 1ns / 1ps
// Command input register, sequence state and result register.
// Depends on isc_pkg and the channel interfaces in isc_if.
module isc_ctrl import isc_pkg::*; #(
  parameter int unsigned MAX_INTERVALS = 16,
  parameter int unsigned COUNTER_BITS  = 16,
  parameter int unsigned IDX_W         = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  isc_cmd_if.sink              cmd,
  isc_res_if.source            res,
  input  logic [SEQ_LEN_W-1:0] seq_len,
  input  table_entry_t         rd_entry,
  output logic [IDX_W-1:0]     rd_addr,
  output logic                 wr_en,
  output logic [IDX_W-1:0]     wr_addr,
  output table_entry_t         wr_entry
);

  // Width that holds both the clamped length and the interval index plus one.
  localparam int unsigned CMP_W = (IDX_W + 1 > SEQ_LEN_W) ? IDX_W + 1 : SEQ_LEN_W;

  // Input register.
  logic                   in_valid;
  logic [CMD_W-1:0]       in_command;
  logic [IDX_FIELD_W-1:0] in_index;
  logic [COUNT_W-1:0]     in_wrap;
  logic [COUNT_W-1:0]     in_step;

  // Sequence state.
  logic                    running;
  logic [IDX_W-1:0]        cur;
  logic [COUNTER_BITS-1:0] cnt;
  logic [COUNT_W-1:0]      wraps;

  logic                    running_next;
  logic [IDX_W-1:0]        cur_next;
  logic [COUNTER_BITS-1:0] cnt_next;
  logic [COUNT_W-1:0]      wraps_next;

  // Result register contents for the item in the input register.
  logic                   status_next;
  logic                   done_next;
  logic [IDX_FIELD_W-1:0] done_index_next;
  logic                   last_next;

  logic                    advance;
  logic                    fire;
  logic [COUNTER_BITS-1:0] cnt_inc;
  logic [COUNTER_BITS-1:0] step_cmp;
  logic                    in_wrap_phase;
  logic [CMP_W-1:0]        eff_len;
  logic [CMP_W-1:0]        cur_plus;
  logic                    is_last;

  // The pipeline moves whenever the result register is empty or being taken.
  assign advance   = !res.valid || res.ready;
  assign fire      = in_valid && advance;
  assign cmd.ready = !in_valid || advance;

  // Input register: takes a beat whenever it is empty or its content moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_command <= cmd.command;
      in_index   <= cmd.entry_index;
      in_wrap    <= cmd.wrap_count;
      in_step    <= cmd.step_count;
    end
  end

  // Clamp the live length register into 1 .. MAX_INTERVALS.
  always_comb begin
    if (seq_len == '0) begin
      eff_len = CMP_W'(1);
    end else if (CMP_W'(seq_len) > CMP_W'(MAX_INTERVALS)) begin
      eff_len = CMP_W'(MAX_INTERVALS);
    end else begin
      eff_len = CMP_W'(seq_len);
    end
  end

  assign cur_plus = CMP_W'(cur) + CMP_W'(1);
  assign is_last  = cur_plus >= eff_len;

  // The table read tracks the current interval, so rd_entry always holds it.
  // The interval is still counting wraps until wraps matches its wrap count.
  assign cnt_inc       = cnt + COUNTER_BITS'(1);
  assign step_cmp      = COUNTER_BITS'(rd_entry.step);
  assign in_wrap_phase = (wraps != rd_entry.wrap);

  // Next state and result for the item in the input register.
  always_comb begin
    running_next    = running;
    cur_next        = cur;
    cnt_next        = cnt;
    wraps_next      = wraps;
    status_next     = STATUS_OK;
    done_next       = 1'b0;
    done_index_next = '0;
    last_next       = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = IDX_W'(in_index);
    wr_entry.wrap   = in_wrap;
    wr_entry.step   = in_step;

    if (fire) begin
      case (in_command)
        CMD_LOAD: begin
          if (running) begin
            status_next = STATUS_REJECTED;
          end else if (32'(in_index) < MAX_INTERVALS) begin
            wr_en = 1'b1;
          end
        end
        CMD_START: begin
          if (running) begin
            status_next = STATUS_REJECTED;
          end else begin
            running_next = 1'b1;
            cur_next     = '0;
            cnt_next     = '0;
            wraps_next   = '0;
          end
        end
        CMD_TICK: begin
          if (running) begin
            cnt_next = cnt_inc;
            if (in_wrap_phase) begin
              // Counting full counter periods.
              if (cnt_inc == '0) begin
                wraps_next = wraps + COUNT_W'(1);
              end
            end else if (cnt_inc == step_cmp) begin
              // Interval expired: report it and move on or finish.
              done_next       = 1'b1;
              done_index_next = IDX_FIELD_W'(cur);
              cnt_next        = '0;
              wraps_next      = '0;
              if (is_last) begin
                last_next    = 1'b1;
                running_next = 1'b0;
              end else begin
                cur_next = cur + IDX_W'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign rd_addr = cur_next;

  // Sequence state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cur     <= '0;
      cnt     <= '0;
      wraps   <= '0;
    end else begin
      running <= running_next;
      cur     <= cur_next;
      cnt     <= cnt_next;
      wraps   <= wraps_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res.status        <= status_next;
      res.interval_done <= done_next;
      res.done_index    <= done_index_next;
      res.sequence_last <= last_next;
      res.busy_res      <= running_next;
    end
  end

endmodule

FILE: hw/rtl/interval_sequence_countdown_top.sv
`timescale 1ns / 1ps
// Top level of the interval sequence countdown timer.
// Depends on isc_pkg, isc_if, isc_apb_regs, isc_table and isc_ctrl.
//
//   Port        Dir  Protocol        Beat contents
//   cmd         in   valid/ready     command, entry_index, wrap_count, step_count
//   res         out  valid/ready     status, interval_done, done_index,
//                                    sequence_last, busy_res
//   psel..      in   APB write/read  sequence_length at byte address 0
//
// One command beat is taken every clock cycle while the result side is not
// stalled; each gives one result beat through the input register, then the result register.
// The table read is addressed with the next interval index, so ticks run
// back to back across interval boundaries.
// rst is synchronous and clears the control state; the table is undefined
// until loaded.
// A stalled result holds in its register while one more command beat waits in
// the input register.
module interval_sequence_countdown_top import isc_pkg::*; #(
  parameter int unsigned MAX_INTERVALS = 16,
  parameter int unsigned COUNTER_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  isc_cmd_if.sink            cmd,
  isc_res_if.source          res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

  logic [SEQ_LEN_W-1:0] seq_len;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic                 wr_en;
  table_entry_t         rd_entry;
  table_entry_t         wr_entry;

  // Configuration register.
  isc_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seq_len (seq_len)
  );

  // Interval table.
  isc_table #(
    .DEPTH (MAX_INTERVALS),
    .AW    (IDX_W)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  // Command handling and sequencing.
  isc_ctrl #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .COUNTER_BITS  (COUNTER_BITS),
    .IDX_W         (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .res      (res),
    .seq_len  (seq_len),
    .rd_entry (rd_entry),
    .rd_addr  (rd_addr),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry)
  );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the interval sequence countdown timer top level.
// Depends on isc_pkg, isc_if and interval_sequence_countdown_top; predicts each
// result beat in step with the command beats and compares field by field.
module testbench;
  import isc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_COMMANDS = 1400;

  typedef enum logic [1:0] {
    PHASE_IDLE  = 2'd0,
    PHASE_WRAPS = 2'd1,
    PHASE_STEPS = 2'd2
  } timer_phase_e;

  typedef struct {
    logic [CMD_W-1:0]       command;
    logic [IDX_FIELD_W-1:0] entry_index;
    logic [COUNT_W-1:0]     wrap_count;
    logic [COUNT_W-1:0]     step_count;
  } cmd_beat_t;

  typedef struct {
    logic                   status;
    logic                   interval_done;
    logic [IDX_FIELD_W-1:0] done_index;
    logic                   sequence_last;
    logic                   busy_res;
  } timer_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  isc_cmd_if cmd_ch ();
  isc_res_if res_ch ();

  interval_sequence_countdown_top #(
    .MAX_INTERVALS(16),
    .COUNTER_BITS (16)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .res    (res_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Timer state as the testbench expects it to be.
  logic [COUNT_W-1:0]     wrap_tbl [TABLE_DEPTH];
  logic [COUNT_W-1:0]     step_tbl [TABLE_DEPTH];
  logic [COUNT_W-1:0]     tick_cnt;
  logic [COUNT_W-1:0]     wraps_cnt;
  logic [IDX_FIELD_W-1:0] cur_ivl;
  timer_phase_e           phase;
  logic [SEQ_LEN_W-1:0]   seq_len_reg;

  timer_result_t results_due [$];
  int fault_count;
  int effective_commands;
  int idle_cycles;
  bit quiet_mode;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The length register saturates to the range 1..16.
  function automatic int eff_length();
    if (seq_len_reg == 0) return 1;
    if (seq_len_reg > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(seq_len_reg);
  endfunction

  function automatic void open_interval();
    tick_cnt  = '0;
    wraps_cnt = '0;
    phase = (wrap_tbl[cur_ivl] != 0) ? PHASE_WRAPS : PHASE_STEPS;
  endfunction

  // Advance the expected timer state by one command beat.
  function automatic timer_result_t apply_command(cmd_beat_t b);
    timer_result_t r;
    logic running;
    r = '{default: '0};
    running = (phase != PHASE_IDLE);
    case (b.command)
      CMD_LOAD: begin
        // Every 4-bit index is inside the 16-entry table.
        if (running) begin
          r.status = STATUS_REJECTED;
        end else begin
          wrap_tbl[b.entry_index] = b.wrap_count;
          step_tbl[b.entry_index] = b.step_count;
        end
      end
      CMD_START: begin
        if (running) begin
          r.status = STATUS_REJECTED;
        end else begin
          cur_ivl = '0;
          open_interval();
        end
      end
      CMD_TICK: begin
        if (running) begin
          tick_cnt = tick_cnt + COUNT_W'(1);
          if (phase == PHASE_WRAPS) begin
            if (tick_cnt == 0) begin
              wraps_cnt = wraps_cnt + COUNT_W'(1);
              if (wraps_cnt == wrap_tbl[cur_ivl]) phase = PHASE_STEPS;
            end
          end else if (tick_cnt == step_tbl[cur_ivl]) begin
            r.interval_done = 1'b1;
            r.done_index = cur_ivl;
            if (int'(cur_ivl) + 1 >= eff_length()) begin
              r.sequence_last = 1'b1;
              phase = PHASE_IDLE;
              tick_cnt = '0;
              wraps_cnt = '0;
            end else begin
              cur_ivl = cur_ivl + IDX_FIELD_W'(1);
              open_interval();
            end
          end
        end
      end
      default: ;
    endcase
    r.busy_res = (phase != PHASE_IDLE);
    return r;
  endfunction

  function automatic cmd_beat_t make_beat(logic [CMD_W-1:0] c, logic [IDX_FIELD_W-1:0] idx,
                                          logic [COUNT_W-1:0] w, logic [COUNT_W-1:0] s);
    cmd_beat_t b;
    b.command = c;
    b.entry_index = idx;
    b.wrap_count = w;
    b.step_count = s;
    return b;
  endfunction

  function automatic cmd_beat_t random_beat(logic [CMD_W-1:0] c);
    return make_beat(c, IDX_FIELD_W'($urandom), COUNT_W'($urandom), COUNT_W'($urandom));
  endfunction

  // Short intervals keep the run length bounded; 0 would mean a full period.
  function automatic logic [COUNT_W-1:0] short_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return COUNT_W'($urandom_range(1, 8));
    if (r < 95) return COUNT_W'($urandom_range(9, 40));
    return COUNT_W'($urandom_range(41, 200));
  endfunction

  // Mostly back-to-back beats, sometimes short gaps, rarely long ones.
  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic int random_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 4);
    if (r < 80) return $urandom_range(5, 15);
    if (r < 88) return 16;
    if (r < 94) return 0;
    return $urandom_range(17, 31);
  endfunction

  // Commands that a running sequence must reject or ignore.
  function automatic cmd_beat_t running_noise();
    case ($urandom_range(0, 2))
      0:       return random_beat(CMD_LOAD);
      1:       return random_beat(CMD_START);
      default: return random_beat(CMD_UNUSED);
    endcase
  endfunction

  // Commands while idle that must not disturb the programmed entries.
  function automatic cmd_beat_t idle_noise();
    int r;
    r = $urandom_range(0, 2);
    if (r == 2 && eff_length() < TABLE_DEPTH)
      return make_beat(CMD_LOAD, IDX_FIELD_W'($urandom_range(eff_length(), TABLE_DEPTH - 1)),
                       COUNT_W'($urandom), COUNT_W'($urandom));
    if (r == 1) return random_beat(CMD_UNUSED);
    return random_beat(CMD_TICK);
  endfunction

  // Send one command beat and record the result it must produce.
  task automatic send_beat(cmd_beat_t b);
    timer_result_t r;
    logic was_running;
    cmd_ch.valid       <= 1'b1;
    cmd_ch.command     <= b.command;
    cmd_ch.entry_index <= b.entry_index;
    cmd_ch.wrap_count  <= b.wrap_count;
    cmd_ch.step_count  <= b.step_count;
    do @(posedge clk); while (!cmd_ch.ready);
    was_running = (phase != PHASE_IDLE);
    r = apply_command(b);
    results_due.push_back(r);
    if (!(b.command == CMD_UNUSED || (b.command == CMD_TICK && !was_running) ||
          r.status == STATUS_REJECTED))
      effective_commands++;
  endtask

  task automatic hold_off_input(int n);
    if (n > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending until every expected result beat has come back.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write the sequence length register once the block has gone quiet.
  task automatic set_length(int len);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SEQ_LEN, 2'b00};
    pwdata  <= PDATA_W'(len);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    seq_len_reg = SEQ_LEN_W'(len);
  endtask

  task automatic program_entries();
    for (int i = 0; i < eff_length(); i++) begin
      send_beat(make_beat(CMD_LOAD, IDX_FIELD_W'(i), '0, short_step()));
      hold_off_input(pick_gap());
    end
  endtask

  // Tick a running sequence, mixing in commands that must be rejected.
  task automatic run_ticks(int max_ticks, int noise_pct);
    int n;
    n = 0;
    while (phase != PHASE_IDLE && n < max_ticks) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_beat(running_noise());
      end else begin
        send_beat(random_beat(CMD_TICK));
        n++;
      end
      hold_off_input(pick_gap());
    end
  endtask

  task automatic start_sequence();
    send_beat(random_beat(CMD_START));
    hold_off_input(pick_gap());
  endtask

  // Field extremes while idle, then a table of short intervals.
  task automatic test_idle_commands_and_table();
    send_beat(make_beat(CMD_UNUSED, '1, '1, '1));
    send_beat(make_beat(CMD_TICK, '0, '0, '0));
    send_beat(make_beat(CMD_TICK, '1, '1, '1));
    send_beat(make_beat(CMD_LOAD, '1, '1, '1));
    send_beat(make_beat(CMD_LOAD, '0, '0, '0));
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_beat(make_beat(CMD_LOAD, IDX_FIELD_W'(i), '0, COUNT_W'(i % 3 + 1)));
      hold_off_input(pick_gap());
    end
  endtask

  // Reset length of one interval, with loads and starts rejected mid-run.
  task automatic test_single_interval();
    send_beat(make_beat(CMD_LOAD, '0, '0, 16'd4));
    start_sequence();
    run_ticks(1, 0);
    send_beat(random_beat(CMD_START));
    send_beat(make_beat(CMD_LOAD, '1, '1, '1));
    send_beat(make_beat(CMD_UNUSED, '0, '0, '0));
    run_ticks(1 << 30, 0);
  endtask

  // Longest sequence, and lengths outside 1..16 that saturate.
  task automatic test_length_extremes();
    int lens [4] = '{16, 0, 31, 17};
    foreach (lens[k]) begin
      set_length(lens[k]);
      start_sequence();
      run_ticks(1 << 30, 0);
    end
  endtask

  // Shortening the sequence while it runs ends it at the current interval.
  task automatic test_live_length_change();
    set_length(4);
    program_entries();
    start_sequence();
    while (phase != PHASE_IDLE && cur_ivl < 2) run_ticks(1, 0);
    set_length(2);
    run_ticks(1 << 30, 0);
  endtask

  // A step count of zero takes a full counter period.
  task automatic test_full_period_step();
    quiet_mode = 1'b1;
    set_length(1);
    send_beat(make_beat(CMD_LOAD, '0, '0, '0));
    start_sequence();
    run_ticks(1 << 30, 0);
    quiet_mode = 1'b0;
  endtask

  // One counter wrap before the step phase; the step value passes unnoticed
  // during the wrap, and the next interval follows back to back.
  task automatic test_wrap_phase();
    quiet_mode = 1'b1;
    set_length(2);
    send_beat(make_beat(CMD_LOAD, 4'd0, 16'd1, 16'd2));
    send_beat(make_beat(CMD_LOAD, 4'd1, 16'd0, 16'd1));
    start_sequence();
    run_ticks(1 << 30, 0);
    quiet_mode = 1'b0;
  endtask

  // Mostly well-formed program/start/run sequences with random content.
  task automatic test_random_sequences();
    effective_commands = 0;
    while (effective_commands < RANDOM_COMMANDS) begin
      quiet_mode = ($urandom_range(0, 99) < 15);
      if ($urandom_range(0, 99) < 15) set_length(random_length());
      else if ($urandom_range(0, 99) < 5) drain_results();
      repeat ($urandom_range(0, 3)) begin
        send_beat(idle_noise());
        hold_off_input(pick_gap());
      end
      program_entries();
      start_sequence();
      if ($urandom_range(0, 99) < 10) begin
        run_ticks($urandom_range(1, 40), 8);
        // Only shorten, so no entry outside the programmed ones is reached.
        if (phase != PHASE_IDLE) set_length($urandom_range(0, eff_length()));
      end
      run_ticks(1 << 30, 8);
    end
    quiet_mode = 1'b0;
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endtask

  // Result side: random back-pressure and comparison of each beat.
  initial begin : result_side
    int stall_left;
    int r;
    timer_result_t want;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        if (results_due.size() == 0) begin
          $error("result beat with no command waiting for it");
          fault_count++;
        end else begin
          want = results_due.pop_front();
          check_field("status", 16'(want.status), 16'(res_ch.status));
          check_field("interval_done", 16'(want.interval_done), 16'(res_ch.interval_done));
          check_field("done_index", 16'(want.done_index), 16'(res_ch.done_index));
          check_field("sequence_last", 16'(want.sequence_last), 16'(res_ch.sequence_last));
          check_field("busy_res", 16'(want.busy_res), 16'(res_ch.busy_res));
        end
      end
      if (quiet_mode) begin
        stall_left = 0;
        res_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) stall_left = 0;
        else if (r < 92) stall_left = $urandom_range(1, 3);
        else if (r < 99) stall_left = $urandom_range(4, 12);
        else stall_left = $urandom_range(20, 40);
        res_ch.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Give up when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("interval_sequence_countdown_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset, then the tests in turn.
  initial begin
    cmd_ch.valid       <= 1'b0;
    cmd_ch.command     <= CMD_LOAD;
    cmd_ch.entry_index <= '0;
    cmd_ch.wrap_count  <= '0;
    cmd_ch.step_count  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst     <= 1'b1;
    fault_count = 0;
    effective_commands = 0;
    quiet_mode = 1'b0;
    foreach (wrap_tbl[i]) begin
      wrap_tbl[i] = '0;
      step_tbl[i] = '0;
    end
    tick_cnt = '0;
    wraps_cnt = '0;
    cur_ivl = '0;
    phase = PHASE_IDLE;
    seq_len_reg = SEQ_LEN_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_idle_commands_and_table();
    test_single_interval();
    test_length_extremes();
    test_live_length_change();
    test_full_period_step();
    test_wrap_phase();
    test_random_sequences();

    drain_results();
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("interval_sequence_countdown_top test passed");
    end else begin
      $display("interval_sequence_countdown_top test failed");
    end
    $finish;
  end

endmodule

FILE: interval_sequence_countdown_top.f
hw/rtl/isc_pkg.sv
hw/rtl/isc_if.sv
hw/rtl/isc_apb_regs.sv
hw/rtl/isc_table.sv
hw/rtl/isc_ctrl.sv
hw/rtl/interval_sequence_countdown_top.sv
test/testbench.sv
